// ===== src/sppa_pkg.sv =====
// Shared types and codes for the step pulse phase accumulator.
`default_nettype none

package sppa_pkg;

	// Fixed field widths of the item formats.
	localparam int VelocityW        = 32;
	localparam int IntervalW        = 24;
	localparam int IntervalFracBits = 24;
	localparam int ProductW         = VelocityW + IntervalW;
	localparam int CountW           = 32;
	localparam int PositionW        = 32;
	localparam int MaxVelocityW     = 31;
	localparam int StatusW          = 2;
	localparam int SDataW           = 88;
	localparam int MDataW           = 72;

	// Command codes carried on the input tuser.
	localparam logic CmdAdvance = 1'b0;
	localparam logic CmdPreset  = 1'b1;

	// Result status codes carried on the output tuser.
	localparam logic [StatusW-1:0] StDone   = 2'd0;
	localparam logic [StatusW-1:0] StIdle   = 2'd1;
	localparam logic [StatusW-1:0] StReject = 2'd2;

	// Configuration register indexes.
	localparam logic CfgMaxVelocity = 1'b0;
	localparam logic CfgPulseCap    = 1'b1;

	// Velocity stage output: clamped velocity folded into a magnitude product.
	typedef struct packed {
		logic                dt_zero;
		logic                vel_zero;
		logic                dir;
		logic [ProductW-1:0] prod;
	} incr_t;

	// One result item.
	typedef struct packed {
		logic [PositionW-1:0] position_now;
		logic [StatusW-1:0]   status;
		logic                 direction;
		logic [CountW-1:0]    pulse_count;
	} result_t;

endpackage

`default_nettype wire

// ===== src/sppa_incr.sv =====
// Velocity stage: clamp, magnitude and direction, and the |v| * dt product.
`default_nettype none

module sppa_incr import sppa_pkg::*; (
	input  wire logic signed [VelocityW-1:0]    velocity,
	input  wire logic        [IntervalW-1:0]    interval,
	input  wire logic        [MaxVelocityW-1:0] max_velocity,
	output incr_t                                incr
);

	logic signed [VelocityW:0] vel_w;
	logic signed [VelocityW:0] lim;
	logic signed [VelocityW:0] clamped;
	logic signed [VelocityW:0] neg;
	logic        [VelocityW-1:0] mag;
	logic        clamp_on;

	assign clamp_on = (max_velocity != '0);
	assign vel_w    = {velocity[VelocityW-1], velocity};
	assign lim      = {2'b00, max_velocity};

	always_comb begin
		if (clamp_on && (vel_w > lim)) begin
			clamped = lim;
		end else if (clamp_on && (vel_w < -lim)) begin
			clamped = -lim;
		end else begin
			clamped = vel_w;
		end
	end

	// The magnitude reaches 2^31 at most, so it fits an unsigned 32-bit word.
	assign neg = -clamped;
	assign mag = clamped[VelocityW] ? neg[VelocityW-1:0] : clamped[VelocityW-1:0];

	assign incr.dt_zero  = (interval == '0);
	assign incr.vel_zero = (clamped == '0);
	assign incr.dir      = clamped[VelocityW];
	assign incr.prod     = {{IntervalW{1'b0}}, mag} * {{VelocityW{1'b0}}, interval};

endmodule

`default_nettype wire

// ===== src/sppa_phase_step.sv =====
// Phase stage: accumulate the increment, cap the whole steps, move the position.
`default_nettype none

module sppa_phase_step import sppa_pkg::*; #(
	parameter int PHASE_FRACTION_BITS    = 24,
	parameter int VELOCITY_FRACTION_BITS = 16
) (
	input  wire logic                                preset,
	input  wire logic        [PositionW-1:0]         preset_position,
	input  wire incr_t                               incr,
	input  wire logic        [31+PHASE_FRACTION_BITS:0] phase,
	input  wire logic        [PositionW-1:0]         position,
	input  wire logic        [CountW-1:0]            pulse_cap,
	output result_t                                  res,
	output logic                                     state_we,
	output logic             [31+PHASE_FRACTION_BITS:0] phase_next,
	output logic             [PositionW-1:0]         position_next
);

	localparam int PhaseW   = 32 + PHASE_FRACTION_BITS;
	localparam int IncShift = VELOCITY_FRACTION_BITS + IntervalFracBits - PHASE_FRACTION_BITS;
	localparam int WholeW   = 65 - PHASE_FRACTION_BITS;

	logic [63:0]                      prod_ext;
	logic [63:0]                      inc;
	logic [64:0]                      sum;
	logic [WholeW-1:0]                whole;
	logic [PHASE_FRACTION_BITS-1:0]   frac;
	logic [CountW-1:0]                whole32;
	logic [CountW-1:0]                emitted;
	logic                             phase_ovf;
	logic [PositionW+1:0]             pos_w;
	logic [PositionW+1:0]             emit_w;
	logic [PositionW+1:0]             next_w;
	logic                             pos_ovf;
	logic [PhaseW-1:0]                phase_adv;

	assign prod_ext = {{(64 - ProductW){1'b0}}, incr.prod};

	// Align the product to the phase format; a right shift truncates toward zero.
	if (IncShift >= 0) begin : gen_shr
		assign inc = prod_ext >> IncShift;
	end else begin : gen_shl
		assign inc = prod_ext << (-IncShift);
	end

	assign sum       = {1'b0, inc} + 65'(phase);
	assign whole     = sum[64:PHASE_FRACTION_BITS];
	assign frac      = sum[PHASE_FRACTION_BITS-1:0];
	assign phase_ovf = |whole[WholeW-1:32];
	assign whole32   = whole[31:0];
	assign emitted   = (whole32 > pulse_cap) ? pulse_cap : whole32;

	assign pos_w   = {{2{position[PositionW-1]}}, position};
	assign emit_w  = {2'b00, emitted};
	assign next_w  = incr.dir ? (pos_w - emit_w) : (pos_w + emit_w);
	assign pos_ovf = (next_w[PositionW+1:PositionW-1] != 3'b000) &&
	                 (next_w[PositionW+1:PositionW-1] != 3'b111);

	assign phase_adv = {whole32 - emitted, frac};

	always_comb begin
		res.pulse_count  = '0;
		res.direction    = 1'b0;
		res.position_now = position;
		res.status       = StDone;
		state_we         = 1'b0;
		phase_next       = phase_adv;
		position_next    = next_w[PositionW-1:0];
		if (preset) begin
			res.position_now = preset_position;
			state_we         = 1'b1;
			phase_next       = '0;
			position_next    = preset_position;
		end else if (incr.dt_zero) begin
			res.status = StReject;
		end else if (incr.vel_zero) begin
			res.status = StIdle;
		end else if (phase_ovf || pos_ovf) begin
			res.status = StReject;
		end else begin
			res.pulse_count  = emitted;
			res.direction    = incr.dir;
			res.position_now = next_w[PositionW-1:0];
			state_we         = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/step_pulse_phase_accumulator_unit.sv =====
// Top level of the step pulse phase accumulator.
`default_nettype none

// Turns a stream of control ticks into step pulse counts for a stepper drive.
// An advance item carries a signed Q16.16 velocity and a Q0.24 interval; the
// velocity is clamped to plus or minus max_velocity when that register is
// nonzero, and |v| * dt is added to a Q32.24 phase accumulator. The whole
// steps in the phase, at most pulse_cap of them, are reported with a
// direction, and the signed step position moves by that count. An item with
// a zero interval, or one that would push the phase to 2^32 steps or the
// position out of the signed 32-bit range, is rejected and leaves the state
// alone; a zero velocity reports idle. A preset item clears the phase and
// loads the position. Every item produces exactly one result item. The block
// is a three-register pipeline: an input register, a register after the
// velocity clamp and the 32 by 24 bit multiplier, and the result register
// that follows the phase add. It takes one item per clock cycle unless the
// pipeline is full, and a result is offered on the output as soon as it
// is in the result register. While the output is held off the pipeline keeps
// up to three items, and the input stalls only once all three registers are
// full. Only the last stage reads and writes the phase and the position, so
// items that follow each other closely see each other's updates.
// Configuration writes are taken at any time but belong in periods when no
// item is in flight.
module step_pulse_phase_accumulator_unit import sppa_pkg::*; #(
	parameter int PHASE_FRACTION_BITS    = 24,
	parameter int VELOCITY_FRACTION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write channel.
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data,
	// Input items.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [SDataW-1:0] s_tdata,   // velocity[31:0], interval[55:32],
	                                          // preset_position[87:56]
	input  wire logic              s_tuser,   // command[0]
	// Result items.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [MDataW-1:0]      m_tdata,   // pulse_count[31:0], direction[32],
	                                          // position_now[64:33], zero fill
	output logic [StatusW-1:0]     m_tuser    // status[1:0]
);

	localparam int PhaseW = 32 + PHASE_FRACTION_BITS;

	// Configuration registers.
	logic [MaxVelocityW-1:0] max_velocity_q;
	logic [CountW-1:0]       pulse_cap_q;

	// Motion state.
	logic [PhaseW-1:0]       phase_q;
	logic [PositionW-1:0]    position_q;

	// Input register.
	logic                        valid_s1;
	logic                        cmd_s1;
	logic signed [VelocityW-1:0] velocity_s1;
	logic        [IntervalW-1:0] interval_s1;
	logic        [PositionW-1:0] preset_s1;

	// Register after the multiplier.
	logic                 valid_s2;
	logic                 cmd_s2;
	incr_t                incr_s2;
	logic [PositionW-1:0] preset_s2;

	// Result register.
	logic    out_valid_q;
	result_t out_q;

	incr_t                incr_d;
	result_t              res_d;
	logic                 state_we;
	logic [PhaseW-1:0]    phase_next;
	logic [PositionW-1:0] position_next;

	logic out_load;
	logic s2_free;
	logic s1_move;
	logic s_accept;

	// Each stage advances whenever the stage after it is empty or emptying,
	// so a waiting result does not stop earlier stages that still have room.
	assign out_load = valid_s2 && (!out_valid_q || m_tready);
	assign s2_free  = !valid_s2 || out_load;
	assign s1_move  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s1_move;
	assign s_accept = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_velocity_q <= '0;
			pulse_cap_q    <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgMaxVelocity: max_velocity_q <= cfg_data[MaxVelocityW-1:0];
				CfgPulseCap:    pulse_cap_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	sppa_incr u_incr (
		.velocity     (velocity_s1),
		.interval     (interval_s1),
		.max_velocity (max_velocity_q),
		.incr         (incr_d)
	);

	sppa_phase_step #(
		.PHASE_FRACTION_BITS    (PHASE_FRACTION_BITS),
		.VELOCITY_FRACTION_BITS (VELOCITY_FRACTION_BITS)
	) u_phase_step (
		.preset          (cmd_s2 == CmdPreset),
		.preset_position (preset_s2),
		.incr            (incr_s2),
		.phase           (phase_q),
		.position        (position_q),
		.pulse_cap       (pulse_cap_q),
		.res             (res_d),
		.state_we        (state_we),
		.phase_next      (phase_next),
		.position_next   (position_next)
	);

	// Valid flags and motion state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
			position_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && state_we) begin
				phase_q    <= phase_next;
				position_q <= position_next;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1      <= s_tuser;
			velocity_s1 <= s_tdata[31:0];
			interval_s1 <= s_tdata[55:32];
			preset_s1   <= s_tdata[87:56];
		end
		if (s1_move) begin
			cmd_s2    <= cmd_s1;
			incr_s2   <= incr_d;
			preset_s2 <= preset_s1;
		end
		if (out_load) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.position_now, out_q.direction, out_q.pulse_count};
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire

// ===== src/sppa_checker.sv =====
// Port-level checker for the step pulse phase accumulator, bound to the top level.
`default_nettype none

module sppa_checker import sppa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [MDataW-1:0] m_tdata,
	input wire logic [StatusW-1:0] m_tuser
);

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only the three defined status codes are ever reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == StDone) || (m_tuser == StIdle) || (m_tuser == StReject))
		else $error("undefined status code");

	// Idle and rejected results emit no steps and report forward direction.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == StIdle) || (m_tuser == StReject)) |->
		m_tdata[32:0] == '0)
		else $error("steps reported on an idle or rejected item");

	// When results drain, the pipeline always has room for a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the output drains");

endmodule

bind step_pulse_phase_accumulator_unit sppa_checker u_sppa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the step pulse phase accumulator unit.
`default_nettype none

module testbench;
	import sppa_pkg::*;

	// The unit is built with its default fixed-point formats. For these widths the
	// exact product |v| * dt is brought to the phase format by a right shift.
	localparam int PhaseFrac = 24;
	localparam int VelFrac   = 16;
	localparam int IncShift  = VelFrac + IntervalFracBits - PhaseFrac;

	// Run shape. The output hold-off starts once this many items are in, and
	// both sides stop idling while the accepted count sits in the calm window.
	localparam int HoldAt           = 150;
	localparam int HoldCycles       = 120;
	localparam int CalmFrom         = 400;
	localparam int CalmTo           = 560;
	localparam int SettleCycles     = 6;
	localparam int RandomPerSetting = 125;
	localparam int TimeLimit        = 200_000;

	// Keeps the expected result items of all accepted input items, oldest first,
	// and a private copy of the phase, the position and both registers.
	class pulse_scoreboard;
		longint unsigned         phase;
		logic signed [31:0]      position;
		logic [MaxVelocityW-1:0] velocity_limit;
		logic [CountW-1:0]       step_cap;
		result_t                 expected_reports[$];
		int mismatches, results_seen, presets, advances, idles, rejects;

		function new();
			phase          = '0;
			position       = '0;
			velocity_limit = '0;
			step_cap       = '1;
			mismatches     = 0;
			results_seen   = 0;
			presets        = 0;
			advances       = 0;
			idles          = 0;
			rejects        = 0;
		endfunction

		function void load_register(logic index, logic [31:0] data);
			if (index == CfgMaxVelocity) begin
				velocity_limit = data[MaxVelocityW-1:0];
			end else begin
				step_cap = data;
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Works out the result of one accepted item and updates the state copy.
		function void note_command(logic command, logic [31:0] vel_bits, logic [23:0] dt,
				logic [31:0] preset_bits);
			longint             vel, lim, moved, next_pos, pos_wide;
			longint unsigned    mag, prod, inc, mask, f, whole, frac, emitted;
			logic signed [31:0] next_short;
			logic               reverse;
			result_t            r;
			r = '0;
			r.position_now = position;
			r.status = StReject;
			if (command == CmdPreset) begin
				phase = '0;
				position = preset_bits;
				r.position_now = position;
				r.status = StDone;
			end else if (dt != 0) begin
				vel = longint'($signed(vel_bits));
				if (velocity_limit != 0) begin
					lim = longint'(velocity_limit);
					if (vel > lim) begin
						vel = lim;
					end else if (vel < -lim) begin
						vel = -lim;
					end
				end
				if (vel == 0) begin
					r.status = StIdle;
				end else begin
					reverse = vel < 0;
					mag = reverse ? -vel : vel;
					prod = mag * dt;
					inc = prod >> IncShift;
					mask = (64'd1 << PhaseFrac) - 64'd1;
					f = (phase & mask) + (inc & mask);
					whole = (phase >> PhaseFrac) + (inc >> PhaseFrac) + (f >> PhaseFrac);
					frac = f & mask;
					emitted = (whole > step_cap) ? step_cap : whole;
					pos_wide = longint'(position);
					moved = emitted;
					next_pos = reverse ? pos_wide - moved : pos_wide + moved;
					next_short = next_pos[31:0];
					// Both the phase and the position must stay in range, else the
					// item leaves the state alone.
					if (whole < 64'h1_0000_0000 && longint'(next_short) == next_pos) begin
						phase = ((whole - emitted) << PhaseFrac) | frac;
						position = next_short;
						r.pulse_count = emitted[31:0];
						r.direction = reverse;
						r.position_now = position;
						r.status = StDone;
					end
				end
			end
			if (command == CmdPreset) begin
				presets++;
			end else if (r.status == StDone) begin
				advances++;
			end else if (r.status == StIdle) begin
				idles++;
			end else begin
				rejects++;
			end
			expected_reports.push_back(r);
		endfunction

		// Compares one accepted result item with the oldest expectation.
		function void check_report(result_t got);
			result_t want;
			results_seen++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d arrived with nothing expected: count=%0d dir=%b pos=%0d st=%0d",
						results_seen, got.pulse_count, got.direction,
						$signed(got.position_now), got.status);
				end
			end else begin
				want = expected_reports.pop_front();
				if (got.pulse_count !== want.pulse_count || got.direction !== want.direction ||
						got.position_now !== want.position_now || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: expected count=%0d dir=%b pos=%0d st=%0d",
							results_seen, want.pulse_count, want.direction,
							$signed(want.position_now), want.status);
						$display("result %0d:   actual count=%0d dir=%b pos=%0d st=%0d",
							results_seen, got.pulse_count, got.direction,
							$signed(got.position_now), got.status);
					end
				end
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_index = CfgMaxVelocity;
	logic [31:0]         cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic [SDataW-1:0]   s_tdata   = '0;
	logic                s_tuser   = CmdAdvance;
	logic                m_tready  = 1'b0;
	logic                cfg_ready;
	logic                s_tready;
	logic                m_tvalid;
	logic [MDataW-1:0]   m_tdata;
	logic [StatusW-1:0]  m_tuser;

	int                  accepted_inputs = 0;
	int                  register_writes = 0;
	int                  hold_left       = 0;
	logic                hold_done       = 1'b0;
	logic                calm;
	pulse_scoreboard     board;

	step_pulse_phase_accumulator_unit #(
		.PHASE_FRACTION_BITS(PhaseFrac),
		.VELOCITY_FRACTION_BITS(VelFrac)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Neither side idles while the accepted item count is inside the calm window.
	assign calm = accepted_inputs >= CalmFrom && accepted_inputs < CalmTo;

	// Output side. It stalls at random, and once, after HoldAt items have gone in,
	// it holds off for a long stretch so that the pipeline fills and the unit has
	// to lower s_tready while the sender keeps offering items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_inputs >= HoldAt) begin
			hold_done <= 1'b1;
			hold_left <= HoldCycles;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	// Monitor. Handshakes are sampled at the rising edge, where every input was
	// set by a nonblocking assignment before that edge. The result is checked
	// before the new item is noted; the pipeline latency keeps the two apart.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				// The result struct is laid out as position, status, direction, count.
				board.check_report({m_tdata[64:33], m_tuser, m_tdata[32:0]});
			end
			if (s_tvalid && s_tready) begin
				board.note_command(s_tuser, s_tdata[31:0], s_tdata[55:32], s_tdata[87:56]);
				accepted_inputs <= accepted_inputs + 1;
			end
			if (cfg_valid && cfg_ready) begin
				board.load_register(cfg_index, cfg_data);
				register_writes <= register_writes + 1;
			end
		end
	end

	// Offers one item, after a random gap, and returns at the edge that takes it.
	// When items follow each other, s_tvalid simply stays high.
	task automatic send_item(logic command, logic [31:0] velocity, logic [23:0] interval,
			logic [31:0] preset);
		while (!calm && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= command;
		s_tdata  <= {preset, interval, velocity};
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	// Stops offering items and waits until every expected result has arrived.
	// The first edge lets the monitor note an item taken at the current edge.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes both registers back to back; the unit is idle when this is called.
	task automatic configure(logic [31:0] max_vel, logic [31:0] cap);
		cfg_valid <= 1'b1;
		cfg_index <= CfgMaxVelocity;
		cfg_data  <= max_vel;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_index <= CfgPulseCap;
		cfg_data  <= cap;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	// Random items under one register setting. Presets favor positions close to
	// the ends of the signed range so that position overflow comes up often.
	task automatic random_phase(logic [31:0] max_vel, logic [31:0] cap);
		logic        command;
		logic [31:0] vel, pos;
		logic [23:0] dt;
		wait_until_drained();
		configure(max_vel, cap);
		repeat (RandomPerSetting) begin
			command = ($urandom_range(0, 99) < 8) ? CmdPreset : CmdAdvance;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: vel = $urandom();
				4, 5:       vel = $urandom_range(0, 2**20) - 2**19;
				6: begin
					case ($urandom_range(0, 3))
						0:       vel = 32'h7FFF_FFFF;
						1:       vel = 32'h8000_0000;
						2:       vel = 32'h0000_0001;
						default: vel = 32'hFFFF_FFFF;
					endcase
				end
				7:          vel = 32'h0;
				default:    vel = $urandom_range(0, 2**27) - 2**26;
			endcase
			case ($urandom_range(0, 19))
				0:          dt = 24'h0;
				1, 2:       dt = 24'hFF_FFFF;
				3, 4, 5:    dt = 24'($urandom_range(1, 255));
				default:    dt = 24'($urandom());
			endcase
			case ($urandom_range(0, 3))
				0:          pos = 32'h7FFF_FFFF - $urandom_range(0, 200000);
				1:          pos = 32'h8000_0000 + $urandom_range(0, 200000);
				default:    pos = $urandom();
			endcase
			send_item(command, vel, dt, pos);
		end
	endtask

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: no clamp and no cap. Full-scale velocities both ways, the
		// smallest ones, a zero interval (checked ahead of a zero velocity), and idle.
		send_item(CmdAdvance, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'h8000_0000, 24'hFF_FFFF, 32'hFFFF_FFFF);
		send_item(CmdAdvance, 32'h0000_0001, 24'h00_0001, 32'h0000_0000);
		send_item(CmdAdvance, 32'hFFFF_FFFF, 24'h00_0001, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0000_0005, 24'h00_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0000_0000, 24'h00_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0000_0000, 24'h00_0064, 32'h0000_0000);
		// Presets to both ends of the position range, then moves past each end.
		send_item(CmdPreset,  32'h1234_5678, 24'hAB_CDEF, 32'h7FFF_FFFF);
		send_item(CmdAdvance, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'h8000_0000, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdPreset,  32'hFFFF_FFFF, 24'hFF_FFFF, 32'h8000_0000);
		send_item(CmdAdvance, 32'h8000_0000, 24'h80_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0001_0000, 24'hFF_FFFF, 32'h0000_0000);
		wait_until_drained();

		// Clamp at one step per second with a cap of three steps.
		configure(32'h0001_0000, 32'h0000_0003);
		send_item(CmdPreset,  32'h0000_0000, 24'h00_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'h8000_0000, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0000_8000, 24'hFF_FFFF, 32'h0000_0000);
		wait_until_drained();
		configure(32'h7FFF_FFFF, 32'h0000_0003);
		send_item(CmdAdvance, 32'h0100_0000, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'hFF00_0000, 24'hFF_FFFF, 32'h0000_0000);
		wait_until_drained();

		// A zero cap emits nothing but still reports the direction.
		configure(32'h0000_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'hFFF0_0000, 24'hFF_FFFF, 32'h0000_0000);
		send_item(CmdAdvance, 32'h0010_0000, 24'hFF_FFFF, 32'h0000_0000);

		random_phase(32'h0000_0000, 32'hFFFF_FFFF);
		random_phase($urandom(), $urandom());
		random_phase(32'h7FFF_FFFF, 32'h0000_0000);
		random_phase($urandom_range(1, 2**22), $urandom_range(0, 4));
		random_phase(32'h0000_0001, 32'h0000_0001);
		random_phase(32'hFFFF_FFFF, $urandom_range(0, 40000));

		// With a zero cap the whole steps stay in the phase; a preset clears it,
		// and the next advances run first with that cap and then with none.
		wait_until_drained();
		configure(32'h0000_0000, 32'h0000_0000);
		send_item(CmdPreset,  32'h0000_0000, 24'h00_0000, 32'h0000_0000);
		send_item(CmdAdvance, 32'h8000_0000, 24'hFF_FFFF, $urandom());
		send_item(CmdPreset,  32'h0000_0000, 24'h00_0000, 32'h0000_0040);
		send_item(CmdAdvance, 32'h0002_0000, 24'hFF_FFFF, 32'h0000_0000);
		wait_until_drained();
		configure(32'h0000_0000, 32'hFFFF_FFFF);
		send_item(CmdAdvance, 32'h0002_0000, 24'hFF_FFFF, 32'h0000_0000);
		wait_until_drained();

		$display("Checked %0d results over %0d register writes: %0d presets, %0d advances,",
			board.results_seen, register_writes, board.presets, board.advances);
		$display("%0d idle, %0d rejected, %0d mismatches, %0d results still owed.",
			board.idles, board.rejects, board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("[step_pulse_phase_accumulator_unit] OK");
		end else begin
			$display("[step_pulse_phase_accumulator_unit] ERROR");
		end
		$finish;
	end

	// Watchdog, several times the length of the slowest correct run.
	initial begin
		#(TimeLimit);
		$display("[step_pulse_phase_accumulator_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/sppa_pkg.sv
src/sppa_incr.sv
src/sppa_phase_step.sv
src/step_pulse_phase_accumulator_unit.sv
src/sppa_checker.sv
tb/sv/testbench.sv
